FILE: rtl/mf3_pkg.sv
package mf3_pkg;

   // fixed field widths
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 12;
   localparam int ROW_W      = 12;
   localparam int OUT_COL_W  = 10;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int WIN_SIZE   = 9;

   // register reset values and lower bounds
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // position info that rides along with a window
   typedef struct packed {
      logic [ROW_W-1:0]     out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 frame_done;
   } meta_type;

endpackage

FILE: rtl/mf3_req_if.sv
interface mf3_req_if #(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

FILE: rtl/mf3_rsp_if.sv
interface mf3_rsp_if #(
   parameter int PIXEL_BITS = 8
);
   import mf3_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] median;
   logic [ROW_W-1:0]      out_row;
   logic [OUT_COL_W-1:0]  out_col;
   logic                  frame_done;

   modport source (output valid, output median, output out_row, output out_col,
                   output frame_done, input ready);
   modport sink   (input valid, input median, input out_row, input out_col,
                   input frame_done, output ready);
endinterface

FILE: rtl/mf3_linebuf.sv
// Line buffer RAM: one write port, one read port, registered read data.
module mf3_linebuf #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/mf3_median.sv
// Median-of-nine sorting network split over two register stages; the second is the output register.
module mf3_median #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic [mf3_pkg::WIN_SIZE-1:0][PIXEL_BITS-1:0]   in_win,
   input  mf3_pkg::meta_type                              in_meta,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic [PIXEL_BITS-1:0]                          out_median,
   output mf3_pkg::meta_type                              out_meta
);
   import mf3_pkg::*;

   // compare-exchange pairs, first three layers then the rest
   localparam int NA = 9;
   localparam int NB = 10;
   localparam int A_LO [NA] = '{1, 4, 7, 0, 3, 6, 1, 4, 7};
   localparam int A_HI [NA] = '{2, 5, 8, 1, 4, 7, 2, 5, 8};
   localparam int B_LO [NB] = '{0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
   localparam int B_HI [NB] = '{3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

   logic [PIXEL_BITS-1:0] pa [WIN_SIZE];
   logic [PIXEL_BITS-1:0] pb [WIN_SIZE];
   logic [PIXEL_BITS-1:0] a_lo, a_hi, b_lo, b_hi;

   logic                  a_valid_ff;
   logic [PIXEL_BITS-1:0] a_win_ff [WIN_SIZE];
   meta_type              a_meta_ff;
   logic                  o_valid_ff;
   logic [PIXEL_BITS-1:0] o_median_ff;
   meta_type              o_meta_ff;

   logic a_adv;

   assign a_adv    = a_valid_ff && (!o_valid_ff || out_ready);
   assign in_ready = !a_valid_ff || a_adv;

   // first layers of the network
   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         pa[i] = in_win[i];
      end
      a_lo = '0;
      a_hi = '0;
      for (int j = 0; j < NA; j++) begin
         a_lo = (pa[A_LO[j]] > pa[A_HI[j]]) ? pa[A_HI[j]] : pa[A_LO[j]];
         a_hi = (pa[A_LO[j]] > pa[A_HI[j]]) ? pa[A_LO[j]] : pa[A_HI[j]];
         pa[A_LO[j]] = a_lo;
         pa[A_HI[j]] = a_hi;
      end
   end

   // remaining layers, median lands in slot 4
   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         pb[i] = a_win_ff[i];
      end
      b_lo = '0;
      b_hi = '0;
      for (int j = 0; j < NB; j++) begin
         b_lo = (pb[B_LO[j]] > pb[B_HI[j]]) ? pb[B_HI[j]] : pb[B_LO[j]];
         b_hi = (pb[B_LO[j]] > pb[B_HI[j]]) ? pb[B_LO[j]] : pb[B_HI[j]];
         pb[B_LO[j]] = b_lo;
         pb[B_HI[j]] = b_hi;
      end
   end

   // stage A register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_ready) begin
         a_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         a_win_ff  <= pa;
         a_meta_ff <= in_meta;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (a_adv) begin
         o_valid_ff <= 1'b1;
      end else if (out_ready) begin
         o_valid_ff <= 1'b0;
      end
      if (a_adv) begin
         o_median_ff <= pb[4];
         o_meta_ff   <= a_meta_ff;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_median = o_median_ff;
   assign out_meta   = o_meta_ff;
endmodule

FILE: rtl/median_filter_3x3.sv
// Channel   Dir  Beat contents                              Handshake
// req_chan  in   pixel                                      valid/ready
// rsp_chan  out  median, out_row, out_col, frame_done       valid/ready
// csr_*     in   csr_index, csr_data                        csr_wr_en, no wait
//
// One pixel beat per clock unless rsp_chan stalls; RAM can read and write once per
// cycle. A result follows its below-right pixel's beat via stages 1, 2, A, output.
// Synchronous reset clears counters, window and pipeline valids, and loads
// width 640 / height 480; line buffer RAM is not cleared.
// A stalled rsp_chan fills the pipeline (up to four beats) before req_chan stalls.
module median_filter_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   mf3_req_if.sink                         req_chan,
   mf3_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;

   // configuration and counters
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [WIDTH_W-1:0]  width_wr;
   logic [HEIGHT_W-1:0] height_wr;

   // stage 1: RAM read in flight
   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [COL_W-1:0]      s1_addr_ff;
   logic                  s1_emit_ff;
   meta_type              s1_meta_ff;

   // stage 2: window ready for sorting
   logic                                 s2_valid_ff;
   meta_type                             s2_meta_ff;
   logic [WIN_SIZE-1:0][PIXEL_BITS-1:0]  win_ff;

   logic                    accept, s1_adv, s2_ready, med_ready;
   logic                    col_last, row_last, emit;
   meta_type                meta_in;
   logic [2*PIXEL_BITS-1:0] rd_data;
   logic [PIXEL_BITS-1:0]   rd_up, rd_mid;

   assign accept   = req_chan.valid && req_chan.ready;
   assign s2_ready = !s2_valid_ff || med_ready;
   assign s1_adv   = s1_valid_ff && s2_ready;
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   // position decode for the incoming beat
   assign col_last = CMP_W'(col_ff) >= (CMP_W'(width_ff) - CMP_W'(1));
   assign row_last = row_ff >= (height_ff - ROW_W'(1));
   assign emit     = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign meta_in.out_row    = row_ff - ROW_W'(1);
   assign meta_in.out_col    = OUT_COL_W'(col_ff - COL_W'(1));
   assign meta_in.frame_done = row_last && col_last;

   // clamp written register values
   always_comb begin
      width_wr = csr_data[WIDTH_W-1:0];
      if (width_wr < WIDTH_MIN) begin
         width_wr = WIDTH_MIN;
      end else if (int'(width_wr) > MAX_WIDTH) begin
         width_wr = WIDTH_W'(MAX_WIDTH);
      end
      height_wr = csr_data[HEIGHT_W-1:0];
      if (height_wr < HEIGHT_MIN) begin
         height_wr = HEIGHT_MIN;
      end
   end

   // registers and raster counters; any valid write restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_ff <= width_wr;
               col_ff   <= '0;
               row_ff   <= '0;
            end
            CSR_FRAME_HEIGHT: begin
               height_ff <= height_wr;
               col_ff    <= '0;
               row_ff    <= '0;
            end
            default: ;
         endcase
      end else if (accept) begin
         if (col_last) begin
            col_ff <= '0;
            row_ff <= row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (accept) begin
         s1_pixel_ff <= req_chan.pixel;
         s1_addr_ff  <= col_ff;
         s1_emit_ff  <= emit;
         s1_meta_ff  <= meta_in;
      end
   end

   // line buffers: entry holds {upper, middle}; write back shifts a row up
   mf3_linebuf #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (2 * PIXEL_BITS)
   ) u_linebuf (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data ({rd_mid, s1_pixel_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   assign rd_up  = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign rd_mid = rd_data[PIXEL_BITS-1:0];

   // window shift and stage 2 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else if (s1_adv) begin
         s2_valid_ff <= s1_emit_ff;
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]   <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= rd_up;
         win_ff[5] <= rd_mid;
         win_ff[8] <= s1_pixel_ff;
      end else if (med_ready) begin
         s2_valid_ff <= 1'b0;
      end
      if (s1_adv) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   meta_type out_meta;

   mf3_median #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_median (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid_ff),
      .in_ready   (med_ready),
      .in_win     (win_ff),
      .in_meta    (s2_meta_ff),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_median (rsp_chan.median),
      .out_meta   (out_meta)
   );

   assign rsp_chan.out_row    = out_meta.out_row;
   assign rsp_chan.out_col    = out_meta.out_col;
   assign rsp_chan.frame_done = out_meta.frame_done;
endmodule

FILE: tb/tb.sv
module tb;
   import mf3_pkg::*;

   localparam int LINE_DEPTH = 1024;
   localparam int PIX_W      = 8;
   // no accepted beat on either channel for this long means the block hung
   localparam int STALL_LIMIT = 2000;
   // register slots that the block does not implement
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] median;
      meta_type         meta;
   } median_beat_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   mf3_req_if #(.PIXEL_BITS(PIX_W)) req_chan ();
   mf3_rsp_if #(.PIXEL_BITS(PIX_W)) rsp_chan ();

   median_filter_3x3 #(
      .MAX_WIDTH  (LINE_DEPTH),
      .PIXEL_BITS (PIX_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // filter state as the testbench sees it
   logic [PIX_W-1:0] two_rows_up [LINE_DEPTH];
   logic [PIX_W-1:0] one_row_up [LINE_DEPTH];
   logic [PIX_W-1:0] neighborhood [WIN_SIZE];
   int unsigned      active_width  = WIDTH_RESET;
   int unsigned      active_height = HEIGHT_RESET;
   int unsigned      pixel_col = 0;
   int unsigned      pixel_row = 0;

   median_beat_t expected_medians [$];
   int           mismatch_count = 0;
   int           send_idle_pct  = 0;
   int           recv_idle_pct  = 0;
   int           hold_off_left  = 0;
   int           quiet_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (neighborhood[i]) neighborhood[i] = '0;
   end

   // fifth smallest of the nine window values
   function automatic logic [PIX_W-1:0] median_of_window();
      logic [PIX_W-1:0] sorted [WIN_SIZE];
      logic [PIX_W-1:0] tmp;
      foreach (neighborhood[i]) sorted[i] = neighborhood[i];
      for (int i = 0; i < WIN_SIZE - 1; i++) begin
         for (int j = 0; j < WIN_SIZE - 1 - i; j++) begin
            if (sorted[j] > sorted[j+1]) begin
               tmp         = sorted[j];
               sorted[j]   = sorted[j+1];
               sorted[j+1] = tmp;
            end
         end
      end
      return sorted[4];
   endfunction

   // register write: clamp, then restart the frame
   function automatic void load_register(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] data);
      int unsigned v;
      if (idx == CSR_FRAME_WIDTH) begin
         v = data[WIDTH_W-1:0];
         if (v < WIDTH_MIN) v = WIDTH_MIN;
         if (v > LINE_DEPTH) v = LINE_DEPTH;
         active_width = v;
         pixel_col = 0;
         pixel_row = 0;
      end else if (idx == CSR_FRAME_HEIGHT) begin
         v = data[HEIGHT_W-1:0];
         if (v < HEIGHT_MIN) v = HEIGHT_MIN;
         active_height = v;
         pixel_col = 0;
         pixel_row = 0;
      end
   endfunction

   // shift one pixel in; queue a median once the window covers an interior pixel
   function automatic void push_pixel(input logic [PIX_W-1:0] px);
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      median_beat_t     beat;
      up  = two_rows_up[pixel_col];
      mid = one_row_up[pixel_col];
      two_rows_up[pixel_col] = mid;
      one_row_up[pixel_col]  = px;
      for (int k = 0; k < 3; k++) begin
         neighborhood[k*3]   = neighborhood[k*3+1];
         neighborhood[k*3+1] = neighborhood[k*3+2];
      end
      neighborhood[2] = up;
      neighborhood[5] = mid;
      neighborhood[8] = px;
      if (pixel_row >= 2 && pixel_col >= 2) begin
         beat.median          = median_of_window();
         beat.meta.out_row    = ROW_W'(pixel_row - 1);
         beat.meta.out_col    = OUT_COL_W'(pixel_col - 1);
         beat.meta.frame_done = (pixel_row + 1 >= active_height) &&
                                (pixel_col + 1 >= active_width);
         expected_medians.push_back(beat);
      end
      if (pixel_col + 1 >= active_width) begin
         pixel_col = 0;
         pixel_row = (pixel_row + 1 >= active_height) ? 0 : pixel_row + 1;
      end else begin
         pixel_col = pixel_col + 1;
      end
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 8'hFF : 8'h00;
         1: return PIX_W'($urandom_range(130, 126));   // clustered, many ties
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // input beats feed the predictor
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) push_pixel(req_chan.pixel);
   end

   // compare each result beat with the oldest expected median
   always @(posedge clock) begin : compare_results
      median_beat_t got;
      median_beat_t want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
         got.median          = rsp_chan.median;
         got.meta.out_row    = rsp_chan.out_row;
         got.meta.out_col    = rsp_chan.out_col;
         got.meta.frame_done = rsp_chan.frame_done;
         if (expected_medians.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: median %0d row %0d col %0d done %0b",
                        got.median, got.meta.out_row, got.meta.out_col,
                        got.meta.frame_done);
         end else begin
            want = expected_medians.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: exp median %0d row %0d col %0d done %0b, %s",
                           want.median, want.meta.out_row, want.meta.out_col,
                           want.meta.frame_done,
                           $sformatf("got median %0d row %0d col %0d done %0b",
                                     got.median, got.meta.out_row, got.meta.out_col,
                                     got.meta.frame_done));
            end
         end
      end
   end

   // result-side ready: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // offer one pixel beat, with random gaps ahead of it; returns on the accepting edge
   task automatic send_pixel(input logic [PIX_W-1:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= px;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   task automatic stop_sending();
      req_chan.valid <= 1'b0;
   endtask

   // all medians back, then let the pipeline run dry
   task automatic wait_idle();
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      load_register(idx, data);
      @(posedge clock);
   endtask

   // smallest frames: clamped sizes, pixel extremes, frame wrap, ignored register slots
   task automatic test_directed_frames();
      logic [PIX_W-1:0] frame_a [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                                        8'd255, 8'd0, 8'd255, 8'd0};
      logic [PIX_W-1:0] frame_b [9] = '{8'd9, 8'd1, 8'd8, 8'd2, 8'd7,
                                        8'd3, 8'd6, 8'd4, 8'd5};
      logic [PIX_W-1:0] frame_c [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                        8'd0, 8'd255, 8'd0, 8'd255};
      write_register(CSR_FRAME_WIDTH, 12'd0);
      write_register(CSR_FRAME_HEIGHT, 12'd1);
      foreach (frame_a[i]) send_pixel(frame_a[i]);
      foreach (frame_b[i]) send_pixel(frame_b[i]);
      for (int i = 0; i < 4; i++) send_pixel(frame_c[i]);
      stop_sending();
      wait_idle();
      // writes to unused slots must not restart the frame
      write_register(CSR_UNUSED_A, 12'hFFF);
      write_register(CSR_UNUSED_B, 12'h000);
      for (int i = 4; i < 9; i++) send_pixel(frame_c[i]);
      stop_sending();
      wait_idle();
   endtask

   // width clamped from above on a short run, then tallest height, cut short
   task automatic test_size_extremes();
      write_register(CSR_FRAME_WIDTH, 12'hFFF);
      write_register(CSR_FRAME_HEIGHT, 12'd3);
      repeat (64) send_pixel(random_pixel());
      stop_sending();
      wait_idle();
      write_register(CSR_FRAME_HEIGHT, 12'hFFF);
      write_register(CSR_FRAME_WIDTH, 12'd3);
      repeat (60) send_pixel(random_pixel());
      stop_sending();
      wait_idle();
   endtask

   // small random frames, some cut short by a restart, some run back to back
   task automatic test_random_frames(input int n_items);
      int sent;
      int frame_len;
      int pick;
      int r;
      logic [CSR_DATA_W-1:0] code;
      sent = 0;
      while (sent < n_items) begin
         if (sent == 0 || $urandom_range(99) < 70) begin
            stop_sending();
            wait_idle();
            pick = $urandom_range(2);
            if (pick != 1) begin
               r = $urandom_range(99);
               if (r < 10)      code = CSR_DATA_W'($urandom_range(2));
               else if (r < 90) code = CSR_DATA_W'($urandom_range(12, 3));
               else             code = CSR_DATA_W'($urandom_range(40, 13));
               write_register(CSR_FRAME_WIDTH, code);
            end
            if (pick != 0) begin
               if ($urandom_range(99) < 10) code = CSR_DATA_W'($urandom_range(2));
               else                         code = CSR_DATA_W'($urandom_range(8, 3));
               write_register(CSR_FRAME_HEIGHT, code);
            end
            if ($urandom_range(99) < 10)
               write_register($urandom_range(1) ? CSR_UNUSED_A : CSR_UNUSED_B,
                              CSR_DATA_W'($urandom));
         end
         frame_len = active_width * active_height;
         if ($urandom_range(99) < 20) frame_len = $urandom_range(frame_len, 1);
         repeat (frame_len) send_pixel(random_pixel());
         sent += frame_len;
      end
      stop_sending();
      wait_idle();
   endtask

   // result side holds off for a long stretch while pixels keep coming
   task automatic test_output_hold_off();
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      write_register(CSR_FRAME_WIDTH, 12'd6);
      write_register(CSR_FRAME_HEIGHT, 12'd10);
      hold_off_left = 300;
      repeat (60) send_pixel(random_pixel());
      stop_sending();
      wait_idle();
      send_idle_pct = saved_pct;
   endtask

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_FRAME_WIDTH;
      csr_data       <= '0;
      req_chan.valid <= 1'b0;
      req_chan.pixel <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      recv_idle_pct = 55;
      test_directed_frames();
      test_size_extremes();
      test_random_frames(540);

      send_idle_pct = 55;
      recv_idle_pct = 31;
      test_random_frames(540);
      test_output_hold_off();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(540);

      stop_sending();
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_medians.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
rtl/mf3_pkg.sv
rtl/mf3_req_if.sv
rtl/mf3_rsp_if.sv
rtl/mf3_linebuf.sv
rtl/mf3_median.sv
rtl/median_filter_3x3.sv
tb/tb.sv
